// ===== hdl/dense_matrix_multiply_top_macros.svh =====
// ----------------------------------------------------------------------------
// dense_matrix_multiply_top_macros
// Assertion macros shared by the matrix multiply RTL.
// ----------------------------------------------------------------------------
`ifndef DENSE_MATRIX_MULTIPLY_TOP_MACROS_SVH
`define DENSE_MATRIX_MULTIPLY_TOP_MACROS_SVH

`ifndef SYNTH

// Checked on every rising edge while out of reset.
`define DMM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define DMM_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define DMM_ASSERT(lbl, clk, rstn, prop, msg)
`define DMM_ASSERT_NORST(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/dmm_pkg.sv =====
// ----------------------------------------------------------------------------
// dmm_pkg
// Types and fixed widths of the dense matrix multiply block.
// ----------------------------------------------------------------------------
package dmm_pkg;

  localparam int ELEM_W = 16;  // Q8.8 element
  localparam int PRODW  = 32;  // one Q16.16 partial product
  localparam int PROD_W = 35;  // Q19.16 dot product
  localparam int IDX_W  = 3;   // row / column index on the result
  localparam int CFG_W  = 4;   // matrix_size register

  localparam logic [CFG_W-1:0] RST_MATRIX_SIZE = 4'd8;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  // Tag that travels with each issued multiply through the MAC pipe.
  typedef struct packed {
    logic             first_k;     // first term of a dot product
    logic             last_k;      // last term of a dot product
    logic             final_item;  // last term of the last product element
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

endpackage

// ===== hdl/dmm_store.sv =====
// ----------------------------------------------------------------------------
// dmm_store
// Operand memories for A and B: one write port, one registered read each.
// ----------------------------------------------------------------------------
module dmm_store #(
  parameter int MAX_DIM = 8
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic                                    wsel_right_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      waddr_i,
  input  logic signed [dmm_pkg::ELEM_W-1:0]       wdata_i,
  input  logic                                    re_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      raddr_a_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      raddr_b_i,
  output logic signed [dmm_pkg::ELEM_W-1:0]       rdata_a_o,
  output logic signed [dmm_pkg::ELEM_W-1:0]       rdata_b_o
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic signed [dmm_pkg::ELEM_W-1:0] left_mem  [DEPTH];
  logic signed [dmm_pkg::ELEM_W-1:0] right_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i && !wsel_right_i) begin
      left_mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= left_mem[raddr_a_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && wsel_right_i) begin
      right_mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_b_o <= right_mem[raddr_b_i];
    end
  end

endmodule

// ===== hdl/dmm_seq.sv =====
// ----------------------------------------------------------------------------
// dmm_seq
// Walks row, column and inner index; issues one pair of operand reads
// per cycle with the tag that the MAC pipe needs.
// ----------------------------------------------------------------------------
`include "dense_matrix_multiply_top_macros.svh"

module dmm_seq #(
  parameter int MAX_DIM = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    go_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]            dim_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0]    nn_i,
  output logic                                    issue_valid_o,
  output dmm_pkg::tag_t                           issue_tag_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      addr_a_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      addr_b_o,
  output logic                                    busy_o
);

  localparam int AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int IW = $clog2(MAX_DIM);
  localparam int TW = dmm_pkg::IDX_W;

  dmm_pkg::seq_state_e state_q, state_d;

  logic [IW-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic [AW-1:0] row_base_q, row_base_d, a_q, a_d, b_q, b_d;
  logic [IW-1:0] dim_m1;
  logic [AW-1:0] dim_ext;
  logic          last_k, last_c, last_r;

  assign dim_m1  = IW'(dim_i - 1'b1);
  assign dim_ext = AW'(dim_i);
  assign last_k  = (k_q == dim_m1);
  assign last_c  = (c_q == dim_m1);
  assign last_r  = (r_q == dim_m1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dmm_pkg::SEQ_IDLE: begin
        if (go_i) begin
          state_d = dmm_pkg::SEQ_RUN;
        end
      end
      dmm_pkg::SEQ_RUN: begin
        if (last_k && last_c && last_r) begin
          state_d = dmm_pkg::SEQ_IDLE;
        end
      end
      default: state_d = dmm_pkg::SEQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    issue_valid_o          = (state_q == dmm_pkg::SEQ_RUN);
    busy_o                 = (state_q == dmm_pkg::SEQ_RUN);
    addr_a_o               = a_q;
    addr_b_o               = b_q;
    issue_tag_o.first_k    = (k_q == '0);
    issue_tag_o.last_k     = last_k;
    issue_tag_o.final_item = last_k && last_c && last_r;
    issue_tag_o.row        = TW'(r_q);
    issue_tag_o.col        = TW'(c_q);
  end

  // index walk: A address steps by one, B address by one row
  always_comb begin
    r_d        = r_q;
    c_d        = c_q;
    k_d        = k_q;
    row_base_d = row_base_q;
    a_d        = a_q;
    b_d        = b_q;
    if (state_q == dmm_pkg::SEQ_IDLE) begin
      if (go_i) begin
        r_d        = '0;
        c_d        = '0;
        k_d        = '0;
        row_base_d = '0;
        a_d        = '0;
        b_d        = '0;
      end
    end else if (last_k) begin
      k_d = '0;
      if (last_c) begin
        c_d        = '0;
        r_d        = r_q + 1'b1;
        row_base_d = row_base_q + dim_ext;
        a_d        = row_base_q + dim_ext;
        b_d        = '0;
      end else begin
        c_d = c_q + 1'b1;
        a_d = row_base_q;
        b_d = AW'(c_q) + AW'(1);
      end
    end else begin
      k_d = k_q + 1'b1;
      a_d = a_q + AW'(1);
      b_d = b_q + dim_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmm_pkg::SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q        <= r_d;
    c_q        <= c_d;
    k_q        <= k_d;
    row_base_q <= row_base_d;
    a_q        <= a_d;
    b_q        <= b_d;
  end

  `DMM_ASSERT(seq_a_in_range, clk_i, rst_ni, issue_valid_o |-> (a_q < nn_i), "A read address beyond matrix")
  `DMM_ASSERT(seq_b_in_range, clk_i, rst_ni, issue_valid_o |-> (b_q < nn_i), "B read address beyond matrix")
  `DMM_ASSERT(seq_stops_after_final, clk_i, rst_ni, issue_valid_o && issue_tag_o.final_item |=> !issue_valid_o, "issue after final term")
  `DMM_ASSERT_NORST(seq_idle_in_reset, clk_i, !rst_ni |=> !busy_o, "sequencer busy after reset edge")

endmodule

// ===== hdl/dmm_mac.sv =====
// ----------------------------------------------------------------------------
// dmm_mac
// Multiply, accumulate over the inner index, register each finished
// product element onto the result ports.
// ----------------------------------------------------------------------------
module dmm_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                issue_valid_i,
  input  dmm_pkg::tag_t                       issue_tag_i,
  input  logic signed [dmm_pkg::ELEM_W-1:0]   rdata_a_i,
  input  logic signed [dmm_pkg::ELEM_W-1:0]   rdata_b_i,
  output logic                                busy_o,
  output logic                                result_strobe_o,
  output logic signed [dmm_pkg::PROD_W-1:0]   product_value_o,
  output logic [dmm_pkg::IDX_W-1:0]           row_index_o,
  output logic [dmm_pkg::IDX_W-1:0]           column_index_o,
  output logic                                last_of_run_o
);

  localparam int PW = dmm_pkg::PROD_W;

  // s1: memory read data present, s2: product registered
  logic                               s1_valid_q, s2_valid_q, strobe_q;
  dmm_pkg::tag_t                      s1_tag_q, s2_tag_q;
  logic signed [dmm_pkg::PRODW-1:0]   prod_q;
  logic signed [PW-1:0]               acc_q, acc_d, out_q;
  logic [dmm_pkg::IDX_W-1:0]          row_q, col_q;
  logic                               last_q;

  assign acc_d = (s2_tag_q.first_k ? PW'(0) : acc_q) + PW'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      s1_valid_q <= issue_valid_i;
      s2_valid_q <= s1_valid_q;
      strobe_q   <= s2_valid_q && s2_tag_q.last_k;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q <= issue_tag_i;
    s2_tag_q <= s1_tag_q;
    prod_q   <= rdata_a_i * rdata_b_i;
    if (s2_valid_q) begin
      acc_q <= acc_d;
    end
    if (s2_valid_q && s2_tag_q.last_k) begin
      out_q  <= acc_d;
      row_q  <= s2_tag_q.row;
      col_q  <= s2_tag_q.col;
      last_q <= s2_tag_q.final_item;
    end
  end

  assign busy_o          = s1_valid_q || s2_valid_q;
  assign result_strobe_o = strobe_q;
  assign product_value_o = out_q;
  assign row_index_o     = row_q;
  assign column_index_o  = col_q;
  assign last_of_run_o   = last_q;

endmodule

// ===== hdl/dense_matrix_multiply_top.sv =====
// ----------------------------------------------------------------------------
// dense_matrix_multiply_top
// Square matrix multiply C = A * B on signed Q8.8 elements, exact Q19.16 out.
// ----------------------------------------------------------------------------
// Load the n*n elements of A and then the n*n elements of B, row-major, one
// item per start pulse while busy is low. The item that carries the last
// element of B launches the product: busy rises on the next cycle. One
// shared 16x16 multiplier fed by one read per cycle from each operand
// memory does one term per cycle. Results come in row-major order, each
// shown for exactly one cycle under result_strobe_o; the receiver cannot
// hold them off, so it must take every strobe. The last element carries
// last_of_run_o and its strobe falls in the first cycle with busy low again.
// matrix_size (0 reads as 1, above MAX_DIM as MAX_DIM) is written through the
// cfg channel, accepted while busy and start are both low; a write drops any
// partial load.
// ----------------------------------------------------------------------------
`include "dense_matrix_multiply_top_macros.svh"

module dense_matrix_multiply_top #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item channel
  input  logic                                start,
  output logic                                busy,
  input  logic signed [dmm_pkg::ELEM_W-1:0]   element_i,
  // configuration channel: matrix_size
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dmm_pkg::CFG_W-1:0]           cfg_data_i,
  // results
  output logic                                result_strobe_o,
  output logic signed [dmm_pkg::PROD_W-1:0]   product_value_o,
  output logic [dmm_pkg::IDX_W-1:0]           row_index_o,
  output logic [dmm_pkg::IDX_W-1:0]           column_index_o,
  output logic                                last_of_run_o
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(MAX_DIM + 1);
  localparam int NW      = $clog2(DEPTH + 1);
  localparam int LW      = $clog2(2 * DEPTH);
  localparam int RST_SZ  = int'(dmm_pkg::RST_MATRIX_SIZE);
  localparam int RST_DIM = (RST_SZ > MAX_DIM) ? MAX_DIM : RST_SZ;

  // size in use, n*n and the index of the last element of B
  logic [CW-1:0] dim_q, dim_d;
  logic [NW-1:0] nn_q, nn_d;
  logic [LW-1:0] last_q, last_d;
  logic [LW-1:0] load_q, load_d;

  logic          cfg_we, in_accept, go;
  logic          wsel_right;
  logic [AW-1:0] waddr;

  logic          seq_valid, seq_busy, mac_busy;
  dmm_pkg::tag_t seq_tag;
  logic [AW-1:0] addr_a, addr_b;
  logic signed [dmm_pkg::ELEM_W-1:0] rdata_a, rdata_b;

  assign busy        = seq_busy || mac_busy;
  // a size write never shares an edge with an element load
  assign cfg_ready_o = !busy && !start;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_accept   = start && !busy;
  assign go          = in_accept && (load_q == last_q);

  // clamp the written size into 1..MAX_DIM
  always_comb begin
    if (cfg_data_i == '0) begin
      dim_d = CW'(1);
    end else if (int'(cfg_data_i) > MAX_DIM) begin
      dim_d = CW'(MAX_DIM);
    end else begin
      dim_d = CW'(cfg_data_i);
    end
    nn_d   = NW'(int'(dim_d) * int'(dim_d));
    last_d = LW'(2 * int'(nn_d) - 1);
  end

  // load counter: A elements first, then B
  always_comb begin
    load_d = load_q;
    if (cfg_we) begin
      load_d = '0;
    end else if (in_accept) begin
      load_d = (load_q == last_q) ? '0 : load_q + 1'b1;
    end
  end

  assign wsel_right = (load_q >= LW'(nn_q));
  assign waddr      = wsel_right ? AW'(load_q - LW'(nn_q)) : AW'(load_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q  <= CW'(RST_DIM);
      nn_q   <= NW'(RST_DIM * RST_DIM);
      last_q <= LW'(2 * RST_DIM * RST_DIM - 1);
      load_q <= '0;
    end else begin
      if (cfg_we) begin
        dim_q  <= dim_d;
        nn_q   <= nn_d;
        last_q <= last_d;
      end
      load_q <= load_d;
    end
  end

  dmm_store #(
    .MAX_DIM(MAX_DIM)
  ) u_store (
    .clk_i       (clk_i),
    .we_i        (in_accept),
    .wsel_right_i(wsel_right),
    .waddr_i     (waddr),
    .wdata_i     (element_i),
    .re_i        (seq_valid),
    .raddr_a_i   (addr_a),
    .raddr_b_i   (addr_b),
    .rdata_a_o   (rdata_a),
    .rdata_b_o   (rdata_b)
  );

  dmm_seq #(
    .MAX_DIM(MAX_DIM)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .go_i         (go),
    .dim_i        (dim_q),
    .nn_i         (nn_q),
    .issue_valid_o(seq_valid),
    .issue_tag_o  (seq_tag),
    .addr_a_o     (addr_a),
    .addr_b_o     (addr_b),
    .busy_o       (seq_busy)
  );

  dmm_mac u_mac (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .issue_valid_i  (seq_valid),
    .issue_tag_i    (seq_tag),
    .rdata_a_i      (rdata_a),
    .rdata_b_i      (rdata_b),
    .busy_o         (mac_busy),
    .result_strobe_o(result_strobe_o),
    .product_value_o(product_value_o),
    .row_index_o    (row_index_o),
    .column_index_o (column_index_o),
    .last_of_run_o  (last_of_run_o)
  );

  `DMM_ASSERT(top_last_load_runs, clk_i, rst_ni, go |=> busy, "last element of B did not start the product")
  `DMM_ASSERT(top_mid_strobe_busy, clk_i, rst_ni, result_strobe_o && !last_of_run_o |-> busy, "block idle before final result")
  `DMM_ASSERT(top_final_strobe_idle, clk_i, rst_ni, result_strobe_o && last_of_run_o |-> !busy, "block busy on final result")

endmodule
